>>> rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescape core
// Transfer payloads, result kinds, decoded-job format and UTF-8 constants.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_BAD_ESC  = 3'd2,
    KIND_BAD_HEX  = 3'd3,
    KIND_BAD_SURR = 3'd4,
    KIND_UNTERM   = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      result_kind;
    logic       run_last;
  } out_item_t;

  // One decoded job: a code point (or raw byte) and its UTF-8 length minus one
  typedef struct packed {
    kind_e       kind;
    logic [20:0] cp;
    logic [1:0]  len;
  } job_t;

  localparam logic [7:0]  CH_QUOTE = 8'h22;
  localparam logic [7:0]  CH_BSL   = 8'h5c;
  localparam logic [7:0]  CH_SLASH = 8'h2f;
  localparam logic [7:0]  CH_N     = 8'h6e;
  localparam logic [7:0]  CH_T     = 8'h74;
  localparam logic [7:0]  CH_R     = 8'h72;
  localparam logic [7:0]  CH_B     = 8'h62;
  localparam logic [7:0]  CH_F     = 8'h66;
  localparam logic [7:0]  CH_U     = 8'h75;

  localparam logic [7:0]  BYTE_LF  = 8'h0a;
  localparam logic [7:0]  BYTE_TAB = 8'h09;
  localparam logic [7:0]  BYTE_CR  = 8'h0d;
  localparam logic [7:0]  BYTE_BS  = 8'h08;
  localparam logic [7:0]  BYTE_FF  = 8'h0c;

  localparam logic [5:0]  SURR_HI_TAG = 6'b110110;  // 0xd800..0xdbff
  localparam logic [5:0]  SURR_LO_TAG = 6'b110111;  // 0xdc00..0xdfff
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [20:0] LIM_1BYTE   = 21'h80;
  localparam logic [20:0] LIM_2BYTE   = 21'h800;
  localparam logic [20:0] LIM_3BYTE   = 21'h10000;

  localparam logic [7:0]  LEAD2 = 8'hc0;
  localparam logic [7:0]  LEAD3 = 8'he0;
  localparam logic [7:0]  LEAD4 = 8'hf0;
  localparam logic [1:0]  CONT_TAG = 2'b10;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: escape parser
// Track the escape state per accepted byte and emit at most one decoded job.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  jsu_pkg::in_item_t in_data_i,
  output logic             push_o,
  output jsu_pkg::job_t    job_o
);
  import jsu_pkg::*;

  typedef enum logic [5:0] {
    MODE_PLAIN     = 6'b000001,
    MODE_ESC       = 6'b000010,
    MODE_HEX_FIRST = 6'b000100,
    MODE_WANT_BS   = 6'b001000,
    MODE_WANT_U    = 6'b010000,
    MODE_HEX_LOW   = 6'b100000
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  high_q, high_d;

  logic [7:0]  c;
  logic [4:0]  hv;
  logic [15:0] acc_nx;
  logic [20:0] pair_cp;

  function automatic job_t make_char(logic [20:0] cp);
    job_t j;
    j.kind = KIND_BYTE;
    j.cp   = cp;
    if (cp < LIM_1BYTE) begin
      j.len = 2'd0;
    end else if (cp < LIM_2BYTE) begin
      j.len = 2'd1;
    end else if (cp < LIM_3BYTE) begin
      j.len = 2'd2;
    end else begin
      j.len = 2'd3;
    end
    return j;
  endfunction

  function automatic job_t make_kind(kind_e k);
    job_t j;
    j.kind = k;
    j.cp   = '0;
    j.len  = 2'd0;
    return j;
  endfunction

  assign c       = in_data_i.in_byte;
  assign hv      = hex_value(c);
  assign acc_nx  = {acc_q[11:0], hv[3:0]};
  assign pair_cp = SUPP_BASE + {1'b0, high_q, acc_nx[9:0]};

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    high_d = high_q;
    push_o = 1'b0;
    job_o  = make_kind(KIND_BYTE);
    if (accept_i) begin
      if (in_data_i.end_of_text) begin
        mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; high_d = '0;
        push_o = 1'b1;
        job_o  = make_kind(KIND_UNTERM);
      end else begin
        case (mode_q)
          MODE_ESC: begin
            mode_d = MODE_PLAIN;
            push_o = 1'b1;
            case (c)
              CH_QUOTE: job_o = make_char({13'd0, CH_QUOTE});
              CH_BSL:   job_o = make_char({13'd0, CH_BSL});
              CH_SLASH: job_o = make_char({13'd0, CH_SLASH});
              CH_N:     job_o = make_char({13'd0, BYTE_LF});
              CH_T:     job_o = make_char({13'd0, BYTE_TAB});
              CH_R:     job_o = make_char({13'd0, BYTE_CR});
              CH_B:     job_o = make_char({13'd0, BYTE_BS});
              CH_F:     job_o = make_char({13'd0, BYTE_FF});
              CH_U: begin
                push_o = 1'b0;
                mode_d = MODE_HEX_FIRST;
                cnt_d  = '0;
                acc_d  = '0;
              end
              default: begin
                cnt_d = '0; acc_d = '0; high_d = '0;
                job_o = make_kind(KIND_BAD_ESC);
              end
            endcase
          end
          MODE_HEX_FIRST, MODE_HEX_LOW: begin
            if (!hv[4]) begin
              mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; high_d = '0;
              push_o = 1'b1;
              job_o  = make_kind(KIND_BAD_HEX);
            end else if (cnt_q != 2'd3) begin
              acc_d = acc_nx;
              cnt_d = cnt_q + 2'd1;
            end else begin
              // Fourth digit: the code unit is complete
              mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; high_d = '0;
              push_o = 1'b1;
              if (mode_q == MODE_HEX_FIRST) begin
                if (acc_nx[15:10] == SURR_HI_TAG) begin
                  push_o = 1'b0;
                  acc_d  = acc_nx;
                  high_d = acc_nx[9:0];
                  mode_d = MODE_WANT_BS;
                end else if (acc_nx[15:10] == SURR_LO_TAG) begin
                  job_o = make_kind(KIND_BAD_SURR);
                end else begin
                  job_o = make_char({5'd0, acc_nx});
                end
              end else begin
                if (acc_nx[15:10] != SURR_LO_TAG) begin
                  job_o = make_kind(KIND_BAD_SURR);
                end else begin
                  job_o = make_char(pair_cp);
                end
              end
            end
          end
          MODE_WANT_BS: begin
            if (c == CH_BSL) begin
              mode_d = MODE_WANT_U;
            end else begin
              mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; high_d = '0;
              push_o = 1'b1;
              job_o  = make_kind(KIND_BAD_SURR);
            end
          end
          MODE_WANT_U: begin
            if (c == CH_U) begin
              mode_d = MODE_HEX_LOW;
              cnt_d  = '0;
              acc_d  = '0;
            end else begin
              mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; high_d = '0;
              push_o = 1'b1;
              job_o  = make_kind(KIND_BAD_SURR);
            end
          end
          default: begin
            mode_d = MODE_PLAIN;
            if (c == CH_QUOTE) begin
              cnt_d = '0; acc_d = '0; high_d = '0;
              push_o = 1'b1;
              job_o  = make_kind(KIND_DONE);
            end else if (c == CH_BSL) begin
              mode_d = MODE_ESC;
            end else begin
              // Raw byte passes through as is, even above 0x7f
              push_o = 1'b1;
              job_o  = make_kind(KIND_BYTE);
              job_o.cp = {13'd0, c};
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      cnt_q  <= '0;
      acc_q  <= '0;
      high_q <= '0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      high_q <= high_d;
    end
  end

endmodule

>>> rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue: decoded-job queue
// Small register queue that decouples the parser from the byte sequencer.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jsu_pkg::job_t head_o
);
  import jsu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("jsu_queue: push into a full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("jsu_queue: pop from an empty queue");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("jsu_queue: fill count beyond depth");
`endif

endmodule

>>> rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: UTF-8 byte sequencer
// Expand the head job into one to four result transfers through an output
// register.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jsu_pkg::job_t      head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jsu_pkg::out_item_t out_data_o
);
  import jsu_pkg::*;

  logic       out_valid_q, out_valid_d;
  out_item_t  out_data_q;
  logic [1:0] idx_q, idx_d;
  logic       adv;
  logic       load;
  logic       last;

  function automatic logic [7:0] enc_byte(logic [20:0] cp, logic [1:0] len,
                                          logic [1:0] idx);
    logic [1:0] rem;
    logic [7:0] b;
    rem = len - idx;
    if (idx == 2'd0) begin
      case (len)
        2'd0:    b = cp[7:0];
        2'd1:    b = LEAD2 | {3'd0, cp[10:6]};
        2'd2:    b = LEAD3 | {4'd0, cp[15:12]};
        default: b = LEAD4 | {5'd0, cp[20:18]};
      endcase
    end else begin
      case (rem)
        2'd0:    b = {CONT_TAG, cp[5:0]};
        2'd1:    b = {CONT_TAG, cp[11:6]};
        default: b = {CONT_TAG, cp[17:12]};
      endcase
    end
    return b;
  endfunction

  assign adv   = !out_valid_q || !out_stall_i;
  assign load  = adv && !empty_i;
  assign last  = (idx_q == head_i.len);
  assign pop_o = load && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = !empty_i;
    end
    if (load) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.out_byte    <= enc_byte(head_i.cp, head_i.len, idx_q);
      out_data_q.result_kind <= head_i.kind;
      out_data_q.run_last    <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_mid_job_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> !empty_i)
    else $error("jsu_back: job left the queue before all its bytes were sent");
  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (idx_q == $past(idx_q)))
    else $error("jsu_back: sequencer advanced while output stalled");
`endif

endmodule

>>> rtl/core/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core: streaming JSON string body decoder
// Unescape string bytes and encode \u code points (and surrogate pairs) as
// UTF-8, with done and error results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one raw byte of string text per transfer (in_valid_i /
//   in_stall_o), starting after the opening quote; end_of_text flags that the
//   source ended. Output channel: one result per transfer (out_valid_o /
//   out_stall_i): a decoded byte, done, or an error kind; run_last marks the
//   final result caused by one input byte. After done or an error the next
//   byte starts a new string.
//   Path: the first result of a byte is written into the job queue and then
//   into the output register, from which it transfers to the receiver.
//   Throughput: one input byte per cycle while the job queue has room; the
//   byte sequencer sends one result per cycle while the receiver does not
//   stall, so a \u escape yields one to three results and a surrogate pair four.
//   Receiver stall: the output register holds its transfer, the sequencer
//   holds, the job queue fills, and in_stall_o rises when the queue is full.
//   Reset: the parser returns to plain mode, the queue empties and no result
//   is pending.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core #(
  parameter int QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jsu_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jsu_pkg::out_item_t out_data_o
);
  import jsu_pkg::*;

  logic accept;
  logic push;
  job_t push_job;
  logic full;
  logic empty;
  logic pop;
  job_t head;

  // Take a byte whenever the queue can hold the job it may produce
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  jsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .job_o     (push_job)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |-> !empty)
    else $error("json_string_unescape_utf8_core: input stalled with queue empty");
`endif

endmodule
